// ----- hdl/dss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_PEEK   = 2'd2,
        FUNC_STATUS = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_func       func;
        logic        side;
        logic [31:0] push_word;
    } t_req;

    typedef struct packed {
        logic [31:0] read_word;
        t_status     status;
        logic        left_empty;
        logic        right_empty;
        logic        store_full;
    } t_rsp;

    // request from the controller to the word memory
    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [ADDR_W-1:0]    addr;
        logic [WORD_BITS-1:0] wdata;
    } t_mem_req;

    // per-request outcome, decided at accept time
    typedef struct packed {
        t_status status;
        logic    rd;
        logic    left_empty;
        logic    right_empty;
        logic    store_full;
    } t_step;

endpackage

`default_nettype wire

// ----- hdl/dss_word_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dss_word_ram (
    input  wire                         i_clk,
    input  dss_pkg::t_mem_req           i_mem,
    output logic [dss_pkg::WORD_BITS-1:0] o_rdata
);
    import dss_pkg::*;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.addr] <= i_mem.wdata;
        end
        if (i_mem.re) begin
            r_rdata <= r_mem[i_mem.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/dss_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dss_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_accept,
    input  dss_pkg::t_req      i_req,
    output dss_pkg::t_mem_req  o_mem,
    output dss_pkg::t_step     o_step
);
    import dss_pkg::*;

    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(DEPTH - 1);
    localparam logic [CNT_W:0]   SUM_DEPTH = (CNT_W + 1)'(DEPTH);

    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] r_right;
    logic [CNT_W-1:0] n_left;
    logic [CNT_W-1:0] n_right;
    logic [CNT_W:0]   cur_sum;
    logic [CNT_W:0]   nxt_sum;
    logic             full_now;
    logic [CNT_W-1:0] side_cnt;
    logic [CNT_W-1:0] push_slot;
    logic [CNT_W-1:0] top_slot;

    assign cur_sum  = {1'b0, r_left} + {1'b0, r_right};
    assign full_now = (cur_sum == SUM_DEPTH);
    assign side_cnt = i_req.side ? r_right : r_left;
    // left grows up from slot 0, right grows down from the last slot
    assign push_slot = i_req.side ? (CNT_LAST - r_right) : r_left;
    assign top_slot  = i_req.side ? (CNT_DEPTH - r_right) : (r_left - 1'b1);

    always_comb begin
        n_left        = r_left;
        n_right       = r_right;
        o_mem.we      = 1'b0;
        o_mem.re      = 1'b0;
        o_mem.addr    = push_slot[ADDR_W-1:0];
        o_mem.wdata   = WORD_BITS'(i_req.push_word);
        o_step.status = ST_DONE;
        o_step.rd     = 1'b0;
        unique case (i_req.func)
            FUNC_PUSH: begin
                if (full_now) begin
                    o_step.status = ST_FULL;
                end else begin
                    o_mem.we = i_accept;
                    if (i_req.side) begin
                        n_right = r_right + 1'b1;
                    end else begin
                        n_left = r_left + 1'b1;
                    end
                end
            end
            FUNC_POP, FUNC_PEEK: begin
                o_mem.addr = top_slot[ADDR_W-1:0];
                if (side_cnt == '0) begin
                    o_step.status = ST_EMPTY;
                end else begin
                    o_mem.re  = i_accept;
                    o_step.rd = 1'b1;
                    if (i_req.func == FUNC_POP) begin
                        if (i_req.side) begin
                            n_right = r_right - 1'b1;
                        end else begin
                            n_left = r_left - 1'b1;
                        end
                    end
                end
            end
            FUNC_STATUS: begin
            end
            default: begin
            end
        endcase
        // flags as they stand after the request
        nxt_sum            = {1'b0, n_left} + {1'b0, n_right};
        o_step.left_empty  = (n_left == '0);
        o_step.right_empty = (n_right == '0);
        o_step.store_full  = (nxt_sum == SUM_DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
        end else if (i_accept) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dual_stack_shared_store_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+-----------------------------
// request   | in        | start & !busy       | i_req (func, side, push_word)
// result    | out       | o_valid, one cycle  | o_rsp (read_word, status, flags)
//
// One request per cycle while busy is low; its result appears in the cycle
// after acceptance. The single-port word memory is read or written at the
// accept edge, so its registered read sets the result delay. Back-to-back
// requests see the previous write, which lands at the earlier accept edge.
// Synchronous active-low reset clears both stack counts; memory is not cleared.
// busy is high only while reset is asserted. The receiver cannot stall.

module dual_stack_shared_store_unit (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    output logic           busy,
    input  dss_pkg::t_req  i_req,
    output logic           o_valid,
    output dss_pkg::t_rsp  o_rsp
);
    import dss_pkg::*;

    logic                 accept;
    t_mem_req             mem_req;
    t_step                step;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                 r_valid;
    t_step                r_step;

    // no request is taken while reset holds the counts
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    dss_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .o_mem    (mem_req),
        .o_step   (step)
    );

    dss_word_ram u_ram (
        .i_clk   (i_clk),
        .i_mem   (mem_req),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
        end
    end

    // result fields; the read word arrives from the memory in the same cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_step <= step;
        end
    end

    assign o_valid           = r_valid;
    assign o_rsp.read_word   = r_step.rd ? 32'(ram_rdata) : 32'd0;
    assign o_rsp.status      = r_step.status;
    assign o_rsp.left_empty  = r_step.left_empty;
    assign o_rsp.right_empty = r_step.right_empty;
    assign o_rsp.store_full  = r_step.store_full;

endmodule

`default_nettype wire
